FILE: design/kic_pkg.sv
`timescale 1ns / 1ps

package kic_pkg;

   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = 7;

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_CENT  = 2'd1;
   localparam logic [1:0] KIND_RUN   = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_LIMIT = 2'd1;
   localparam logic [1:0] STAT_ZERO  = 2'd2;

   localparam logic [1:0] CSR_POINT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_COUNT = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD     = 2'd2;

   localparam logic [10:0] POINT_COUNT_RST   = 11'd1024;
   localparam logic [4:0]  CLUSTER_COUNT_RST = 5'd16;
   localparam logic [6:0]  THRESHOLD_RST     = 7'd1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         entry;
      logic [3:0]         dim;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [6:0]         iterations;
      logic [1:0]         status;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_ASSIGN,
      ST_ASSIGN_WAIT,
      ST_UPD_LBL,
      ST_UPD_LAB,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_DIV_RD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_PCT_WAIT,
      ST_EMIT
   } state_type;

endpackage

FILE: design/kic_stream_if.sv
`timescale 1ns / 1ps

interface kic_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/kic_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module kic_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [kic_pkg::DIV_W-1:0] dividend,
   input  logic [kic_pkg::DIV_W-1:0] divisor,
   output logic                      busy,
   output logic                      done,
   output logic [kic_pkg::DIV_W-1:0] quotient
);

   localparam int W = kic_pkg::DIV_W;

   logic [W:0]                      rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W-1:0]                    den_ff, den_in;
   logic [kic_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [W:0]                      shifted;
   logic [W+1:0]                    trial;

   assign shifted = {rem_ff[W-1:0], quo_ff[W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (!trial[W+1]) begin
            rem_in = trial[W:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + kic_pkg::DIV_CNT_W'(1);
         if (cnt_ff == kic_pkg::DIV_CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/kmeans_integer_clustering_core.sv
`timescale 1ns / 1ps
// Load words (point or centroid element) are written from idle; a centroid read goes through the
// read and emit states. Each run iteration clears the sum memory, assigns every point (a point and
// a centroid element read per cycle), adds each point to its cluster's sums by read-modify-write,
// divides each element of a nonempty centroid on the divider shared with the convergence check,
// zeroes the elements of empty ones, checks convergence, emits the result word. One item at a time.
// Synchronous active-high reset clears control state and sets the registers; memories undefined.
module kmeans_integer_clustering_core #(
   parameter int MAX_POINTS   = 1024,
   parameter int MAX_CLUSTERS = 16,
   parameter int DIMS         = 16,
   parameter int MAX_ITER     = 64
) (
   input  logic        clock,
   input  logic        reset,
   kic_stream_if.sink   req_if,
   kic_stream_if.source rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int PA_W   = $clog2(MAX_POINTS * DIMS);
   localparam int CA_W   = $clog2(MAX_CLUSTERS * DIMS);
   localparam int P_W    = $clog2(MAX_POINTS);
   localparam int PC_W   = $clog2(MAX_POINTS + 1);
   localparam int J_W    = $clog2(MAX_CLUSTERS);
   localparam int NC_W   = $clog2(MAX_CLUSTERS + 1);
   localparam int D_W    = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int ITER_W = $clog2(MAX_ITER + 1);
   localparam logic [D_W-1:0]  D_LAST   = D_W'(DIMS - 1);
   localparam logic [CA_W-1:0] CLR_LAST = CA_W'(MAX_CLUSTERS * DIMS - 1);

   function automatic logic [PA_W-1:0] p_addr(input logic [P_W-1:0] p, input logic [D_W-1:0] d);
      return PA_W'(PA_W'(p) * PA_W'(DIMS) + PA_W'(d));
   endfunction

   function automatic logic [CA_W-1:0] c_addr(input logic [J_W-1:0] j, input logic [D_W-1:0] d);
      return CA_W'(CA_W'(j) * CA_W'(DIMS) + CA_W'(d));
   endfunction

   // ---------------------------------------------------------------- state
   kic_pkg::state_type state_ff, state_in;

   logic [10:0]        point_count_ff;
   logic [4:0]         cluster_count_ff;
   logic [6:0]         threshold_ff;

   logic [P_W-1:0]     p_ff, p_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [CA_W-1:0]    clr_ff, clr_in;
   logic [J_W-1:0]     lab_ff, lab_in;
   logic [PC_W-1:0]    np_ff, np_in;
   logic [NC_W-1:0]    nc_ff, nc_in;
   logic [63:0]        err_ff, err_in;
   logic [63:0]        prev_ff, prev_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               neg_ff, neg_in;
   logic [31:0]        res_data_ff, res_data_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kic_pkg::rsp_payload_type rsp_payload_ff;
   logic               rsp_load;

   // assignment pipeline: stage 1 holds memory data, stage 2 the products
   logic               issue;
   logic               s1_vld_ff, s1_first_ff, s1_last_ff;
   logic [J_W-1:0]     s1_j_ff;
   logic [P_W-1:0]     s1_p_ff;
   logic               s2_vld_ff, s2_first_ff, s2_last_ff;
   logic [J_W-1:0]     s2_j_ff;
   logic [P_W-1:0]     s2_p_ff;
   logic [31:0]        u_ff, xc_ff;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        best_ff, best_in;
   logic [J_W-1:0]     best_lab_ff, best_lab_in;
   logic [31:0]        sq_full, score_now, new_best;
   logic [J_W-1:0]     new_lab;

   // memories
   logic [31:0]        pmem [MAX_POINTS * DIMS];
   logic [31:0]        cmem [MAX_CLUSTERS * DIMS];
   logic [31:0]        smem [MAX_CLUSTERS * DIMS];
   logic [J_W-1:0]     lmem [MAX_POINTS];
   logic               pmem_we, cmem_we, smem_we, lmem_we;
   logic [PA_W-1:0]    pmem_wa, pmem_ra;
   logic [CA_W-1:0]    cmem_wa, cmem_ra, smem_wa, smem_ra;
   logic [P_W-1:0]     lmem_wa, lmem_ra;
   logic [31:0]        pmem_wd, cmem_wd, smem_wd;
   logic [J_W-1:0]     lmem_wd;
   logic [31:0]        pmem_q, cmem_q, smem_q;
   logic [J_W-1:0]     lmem_q;

   // member counts: one read address, cleared per iteration
   logic [PC_W-1:0]    cnt_ff [MAX_CLUSTERS];
   logic               cnt_clear, cnt_inc;
   logic [J_W-1:0]     cnt_addr;
   logic [PC_W-1:0]    cnt_rd;

   // divider
   logic               div_start, div_busy, div_done;
   logic [63:0]        div_num, div_den, div_quo;

   // convergence arithmetic
   logic [63:0]        err_diff, diff100, diff_mag, err_mag;
   logic [31:0]        sum_mag, np_full;
   logic               pt_ok, ct_ok;
   logic               p_last, j_last, d_last;

   kic_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------ datapath
   assign sq_full   = cmem_q * cmem_q;
   assign score_now = (s2_first_ff ? 32'd0 : acc_ff) + u_ff - xc_ff;
   // lower cluster wins ties: replace only on strictly smaller score
   assign new_best  = ((s2_j_ff == '0) || ($signed(score_now) < $signed(best_ff)))
                      ? score_now : best_ff;
   assign new_lab   = ((s2_j_ff == '0) || ($signed(score_now) < $signed(best_ff)))
                      ? s2_j_ff : best_lab_ff;

   assign err_diff = err_ff - prev_ff;
   assign diff100  = (err_diff << 6) + (err_diff << 5) + (err_diff << 2);
   assign diff_mag = diff100[63] ? (64'd0 - diff100) : diff100;
   assign err_mag  = err_ff[63] ? (64'd0 - err_ff) : err_ff;
   assign sum_mag  = smem_q[31] ? (32'd0 - smem_q) : smem_q;

   assign pt_ok = (32'(req_if.payload.entry) < MAX_POINTS) && (32'(req_if.payload.dim) < DIMS);
   assign ct_ok = (32'(req_if.payload.entry) < MAX_CLUSTERS)
                  && (32'(req_if.payload.dim) < DIMS);
   assign np_full = (32'(point_count_ff) > MAX_POINTS) ? MAX_POINTS : 32'(point_count_ff);

   assign p_last = (PC_W'(p_ff) == np_ff - PC_W'(1));
   assign j_last = (NC_W'(j_ff) == nc_ff - NC_W'(1));
   assign d_last = (d_ff == D_LAST);

   assign cnt_rd = cnt_ff[cnt_addr];

   assign req_if.ready   = (state_ff == kic_pkg::ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   // ------------------------------------------------ next state and controls
   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      j_in          = j_ff;
      d_in          = d_ff;
      clr_in        = clr_ff;
      lab_in        = lab_ff;
      np_in         = np_ff;
      nc_in         = nc_ff;
      err_in        = err_ff;
      prev_in       = prev_ff;
      iter_in       = iter_ff;
      rd_ok_in      = rd_ok_ff;
      neg_in        = neg_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      best_lab_in   = best_lab_ff;
      rsp_load      = 1'b0;
      issue         = 1'b0;
      pmem_we = 1'b0; pmem_wa = '0; pmem_wd = '0; pmem_ra = '0;
      cmem_we = 1'b0; cmem_wa = '0; cmem_wd = '0; cmem_ra = '0;
      smem_we = 1'b0; smem_wa = '0; smem_wd = '0; smem_ra = '0;
      lmem_we = 1'b0; lmem_wa = '0; lmem_wd = '0; lmem_ra = '0;
      cnt_clear = 1'b0;
      cnt_inc   = 1'b0;
      cnt_addr  = j_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;

      // close out a score at the last dimension; a point at its last cluster
      if (s2_vld_ff) begin
         acc_in = score_now;
         if (s2_last_ff) begin
            best_in     = new_best;
            best_lab_in = new_lab;
            if (NC_W'(s2_j_ff) == nc_ff - NC_W'(1)) begin
               lmem_we = 1'b1;
               lmem_wa = s2_p_ff;
               lmem_wd = new_lab;
               err_in  = err_ff + {{32{new_best[31]}}, new_best};
            end
         end
      end

      case (state_ff)
         kic_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               case (req_if.payload.kind)
                  kic_pkg::KIND_POINT: begin
                     pmem_we = pt_ok;
                     pmem_wa = p_addr(P_W'(req_if.payload.entry), D_W'(req_if.payload.dim));
                     pmem_wd = req_if.payload.value;
                  end
                  kic_pkg::KIND_CENT: begin
                     cmem_we = ct_ok;
                     cmem_wa = c_addr(J_W'(req_if.payload.entry), D_W'(req_if.payload.dim));
                     cmem_wd = req_if.payload.value;
                  end
                  kic_pkg::KIND_READ: begin
                     cmem_ra  = c_addr(J_W'(req_if.payload.entry), D_W'(req_if.payload.dim));
                     rd_ok_in = ct_ok;
                     state_in = kic_pkg::ST_READ;
                  end
                  kic_pkg::KIND_RUN: begin
                     np_in = PC_W'(np_full);
                     if (cluster_count_ff == 5'd0) begin
                        nc_in = NC_W'(1);
                     end else if (32'(cluster_count_ff) > MAX_CLUSTERS) begin
                        nc_in = NC_W'(MAX_CLUSTERS);
                     end else begin
                        nc_in = NC_W'(cluster_count_ff);
                     end
                     err_in   = '0;
                     prev_in  = '0;
                     iter_in  = '0;
                     clr_in   = '0;
                     state_in = kic_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // a read reports no iterations
         kic_pkg::ST_READ: begin
            res_data_in   = rd_ok_ff ? cmem_q : 32'd0;
            res_status_in = kic_pkg::STAT_OK;
            iter_in       = '0;
            state_in      = kic_pkg::ST_EMIT;
         end

         // sweep the sum memory to zero, drop the member counts
         kic_pkg::ST_CLEAR: begin
            cnt_clear = 1'b1;
            smem_we   = 1'b1;
            smem_wa   = clr_ff;
            clr_in    = clr_ff + CA_W'(1);
            if (clr_ff == CLR_LAST) begin
               p_in = '0;
               j_in = '0;
               d_in = '0;
               state_in = (np_ff == '0) ? kic_pkg::ST_ASSIGN_WAIT : kic_pkg::ST_ASSIGN;
            end
         end

         // stream point and centroid elements into the score pipeline
         kic_pkg::ST_ASSIGN: begin
            issue   = 1'b1;
            pmem_ra = p_addr(p_ff, d_ff);
            cmem_ra = c_addr(j_ff, d_ff);
            if (!d_last) begin
               d_in = d_ff + D_W'(1);
            end else begin
               d_in = '0;
               if (!j_last) begin
                  j_in = j_ff + J_W'(1);
               end else begin
                  j_in = '0;
                  if (!p_last) begin
                     p_in = p_ff + P_W'(1);
                  end else begin
                     state_in = kic_pkg::ST_ASSIGN_WAIT;
                  end
               end
            end
         end

         kic_pkg::ST_ASSIGN_WAIT: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               p_in = '0;
               j_in = '0;
               d_in = '0;
               state_in = (np_ff == '0) ? kic_pkg::ST_DIV_RD : kic_pkg::ST_UPD_LBL;
            end
         end

         kic_pkg::ST_UPD_LBL: begin
            lmem_ra  = p_ff;
            state_in = kic_pkg::ST_UPD_LAB;
         end

         kic_pkg::ST_UPD_LAB: begin
            lab_in   = lmem_q;
            cnt_addr = lmem_q;
            cnt_inc  = 1'b1;
            d_in     = '0;
            state_in = kic_pkg::ST_UPD_RD;
         end

         kic_pkg::ST_UPD_RD: begin
            pmem_ra  = p_addr(p_ff, d_ff);
            smem_ra  = c_addr(lab_ff, d_ff);
            state_in = kic_pkg::ST_UPD_WR;
         end

         // one read-modify-write in flight at a time, so no forwarding
         kic_pkg::ST_UPD_WR: begin
            smem_we = 1'b1;
            smem_wa = c_addr(lab_ff, d_ff);
            smem_wd = smem_q + pmem_q;
            if (!d_last) begin
               d_in     = d_ff + D_W'(1);
               state_in = kic_pkg::ST_UPD_RD;
            end else if (!p_last) begin
               p_in     = p_ff + P_W'(1);
               state_in = kic_pkg::ST_UPD_LBL;
            end else begin
               j_in     = '0;
               d_in     = '0;
               state_in = kic_pkg::ST_DIV_RD;
            end
         end

         kic_pkg::ST_DIV_RD: begin
            smem_ra  = c_addr(j_ff, d_ff);
            state_in = kic_pkg::ST_DIV_START;
         end

         kic_pkg::ST_DIV_START: begin
            if (cnt_rd == '0) begin
               // empty cluster: zero centroid
               cmem_we = 1'b1;
               cmem_wa = c_addr(j_ff, d_ff);
               cmem_wd = '0;
               if (!d_last) begin
                  d_in     = d_ff + D_W'(1);
                  state_in = kic_pkg::ST_DIV_RD;
               end else if (!j_last) begin
                  d_in     = '0;
                  j_in     = j_ff + J_W'(1);
                  state_in = kic_pkg::ST_DIV_RD;
               end else begin
                  iter_in  = iter_ff + ITER_W'(1);
                  state_in = kic_pkg::ST_CHECK;
               end
            end else begin
               div_start = 1'b1;
               div_num   = {32'd0, sum_mag};
               div_den   = 64'(cnt_rd);
               neg_in    = smem_q[31];
               state_in  = kic_pkg::ST_DIV_WAIT;
            end
         end

         kic_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               cmem_we = 1'b1;
               cmem_wa = c_addr(j_ff, d_ff);
               cmem_wd = neg_ff ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
               if (!d_last) begin
                  d_in     = d_ff + D_W'(1);
                  state_in = kic_pkg::ST_DIV_RD;
               end else if (!j_last) begin
                  d_in     = '0;
                  j_in     = j_ff + J_W'(1);
                  state_in = kic_pkg::ST_DIV_RD;
               end else begin
                  iter_in  = iter_ff + ITER_W'(1);
                  state_in = kic_pkg::ST_CHECK;
               end
            end
         end

         // zero error stops before the percent test and the iteration limit
         kic_pkg::ST_CHECK: begin
            if (err_ff == '0) begin
               res_data_in   = '0;
               res_status_in = kic_pkg::STAT_ZERO;
               state_in      = kic_pkg::ST_EMIT;
            end else begin
               div_start = 1'b1;
               div_num   = diff_mag;
               div_den   = err_mag;
               state_in  = kic_pkg::ST_PCT_WAIT;
            end
         end

         kic_pkg::ST_PCT_WAIT: begin
            if (div_done) begin
               res_data_in = '0;
               if (div_quo < 64'(threshold_ff)) begin
                  res_status_in = kic_pkg::STAT_OK;
                  state_in      = kic_pkg::ST_EMIT;
               end else if (iter_ff >= ITER_W'(MAX_ITER)) begin
                  res_status_in = kic_pkg::STAT_LIMIT;
                  state_in      = kic_pkg::ST_EMIT;
               end else begin
                  prev_in  = err_ff;
                  err_in   = '0;
                  clr_in   = '0;
                  state_in = kic_pkg::ST_CLEAR;
               end
            end
         end

         // hold the result until the output register frees up
         kic_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = kic_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kic_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_if.ready);
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= kic_pkg::ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         s1_vld_ff        <= 1'b0;
         s2_vld_ff        <= 1'b0;
         point_count_ff   <= kic_pkg::POINT_COUNT_RST;
         cluster_count_ff <= kic_pkg::CLUSTER_COUNT_RST;
         threshold_ff     <= kic_pkg::THRESHOLD_RST;
         err_ff           <= '0;
         prev_ff          <= '0;
         iter_ff          <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= issue;
         s2_vld_ff    <= s1_vld_ff;
         err_ff       <= err_in;
         prev_ff      <= prev_in;
         iter_ff      <= iter_in;
         if (csr_we) begin
            case (csr_index)
               kic_pkg::CSR_POINT_COUNT:   point_count_ff   <= csr_wdata;
               kic_pkg::CSR_CLUSTER_COUNT: cluster_count_ff <= csr_wdata[4:0];
               kic_pkg::CSR_THRESHOLD:     threshold_ff     <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      j_ff          <= j_in;
      d_ff          <= d_in;
      clr_ff        <= clr_in;
      lab_ff        <= lab_in;
      np_ff         <= np_in;
      nc_ff         <= nc_in;
      rd_ok_ff      <= rd_ok_in;
      neg_ff        <= neg_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      acc_ff        <= acc_in;
      best_ff       <= best_in;
      best_lab_ff   <= best_lab_in;
      s1_first_ff   <= (d_ff == '0);
      s1_last_ff    <= d_last;
      s1_j_ff       <= j_ff;
      s1_p_ff       <= p_ff;
      s2_first_ff   <= s1_first_ff;
      s2_last_ff    <= s1_last_ff;
      s2_j_ff       <= s1_j_ff;
      s2_p_ff       <= s1_p_ff;
      u_ff          <= sq_full >> 1;
      xc_ff         <= pmem_q * cmem_q;
      if (rsp_load) begin
         rsp_payload_ff.data       <= res_data_ff;
         rsp_payload_ff.iterations <= 7'(iter_ff);
         rsp_payload_ff.status     <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_CLUSTERS; k++) begin
         if (cnt_clear) begin
            cnt_ff[k] <= '0;
         end
      end
      if (cnt_inc) begin
         cnt_ff[cnt_addr] <= cnt_rd + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (pmem_we) begin
         pmem[pmem_wa] <= pmem_wd;
      end
      pmem_q <= pmem[pmem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmem_we) begin
         cmem[cmem_wa] <= cmem_wd;
      end
      cmem_q <= cmem[cmem_ra];
   end

   always_ff @(posedge clock) begin
      if (smem_we) begin
         smem[smem_wa] <= smem_wd;
      end
      smem_q <= smem[smem_ra];
   end

   always_ff @(posedge clock) begin
      if (lmem_we) begin
         lmem[lmem_wa] <= lmem_wd;
      end
      lmem_q <= lmem[lmem_ra];
   end

   // ----------------------------------------------------------- assertions
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_label_in_assign: assert property (@(posedge clock) disable iff (reset)
      lmem_we |-> (state_ff == kic_pkg::ST_ASSIGN || state_ff == kic_pkg::ST_ASSIGN_WAIT))
      else $error("label written outside assignment pass");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(MAX_ITER))
      else $error("iteration count past limit");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == kic_pkg::ST_EMIT))
      else $error("result word raised outside emit");

endmodule
